// File: hw/rtl/lris_pkg.sv
// ----------------------------------------------------------------------------
// lris_pkg
// Shared types, sizes and the tanh table for the reservoir step unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lris_pkg;
    localparam int NEURONS    = 64;
    localparam int INPUT_DIM  = 8;
    localparam int OUTPUT_DIM = 8;
    localparam int IN_COLS    = 1 + INPUT_DIM;
    localparam int OUT_COLS   = 1 + INPUT_DIM + NEURONS;
    localparam int NW         = $clog2(NEURONS);
    localparam int UW         = $clog2(INPUT_DIM) > 0 ? $clog2(INPUT_DIM) : 1;
    localparam int OW         = $clog2(OUTPUT_DIM) > 0 ? $clog2(OUTPUT_DIM) : 1;
    localparam int RW_DEPTH   = NEURONS * NEURONS;
    localparam int IW_DEPTH   = NEURONS * IN_COLS;
    localparam int OWT_DEPTH  = OUTPUT_DIM * OUT_COLS;
    localparam int RW_AW      = $clog2(RW_DEPTH);
    localparam int IW_AW      = $clog2(IW_DEPTH);
    localparam int OWT_AW     = $clog2(OWT_DEPTH);
    localparam int ACC_W      = 48;

    typedef enum logic [2:0] {
        ACT_WR_REC   = 3'd0,
        ACT_WR_IN    = 3'd1,
        ACT_WR_OUT   = 3'd2,
        ACT_ELEMENT  = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         row;
        logic [6:0]         col;
        logic [2:0]         element_index;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         output_index;
        logic signed [15:0] output_value;
        logic               last_output;
    } t_out_item;

    // Phase of the datapath sequencer.
    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_PRE, ST_PRE_END, ST_TANH, ST_LEAK, ST_LEAK_END,
        ST_COPY, ST_RO, ST_RO_END, ST_EMIT
    } t_state;

    typedef struct packed {
        logic          clr_acc;   // load bias into accumulator
        logic          mac;       // add product of current operands
        logic [1:0]    src;       // 0 input weight, 1 recurrent, 2 readout
        logic          pre_done;  // store rounded pre
        logic          tanh_go;
        logic          leak_go;
        logic          ro_done;
        logic          clr_x;
    } t_cmd;

    localparam logic [1:0] SRC_IN  = 2'd0;
    localparam logic [1:0] SRC_REC = 2'd1;
    localparam logic [1:0] SRC_OUT = 2'd2;

    function automatic logic signed [13:0] tanh_tab(input logic [5:0] i);
        logic signed [13:0] t;
        unique case (i)
            6'd0: t = 14'sd0;    6'd1: t = 14'sd1003; 6'd2: t = 14'sd1893;
            6'd3: t = 14'sd2602; 6'd4: t = 14'sd3119; 6'd5: t = 14'sd3475;
            6'd6: t = 14'sd3707; 6'd7: t = 14'sd3856; 6'd8: t = 14'sd3949;
            6'd9: t = 14'sd4006; 6'd10: t = 14'sd4041; 6'd11: t = 14'sd4062;
            6'd12: t = 14'sd4076; 6'd13: t = 14'sd4084; 6'd14: t = 14'sd4089;
            6'd15: t = 14'sd4091; 6'd16: t = 14'sd4093; 6'd17: t = 14'sd4094;
            6'd18: t = 14'sd4095; 6'd19: t = 14'sd4095;
            default: t = 14'sd4096;
        endcase
        return t;
    endfunction

    // Round half up from Q24.24 to Q4.12, then saturate to 16 bits.
    function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-13:0] q;
        s = a + ACC_W'(2048);
        q = s[ACC_W-1:12];
        if (q > 32767) return 16'sh7fff;
        if (q < -32768) return 16'sh8000;
        return q[15:0];
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/lris_ram.sv
// ----------------------------------------------------------------------------
// lris_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lris_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/lris_ctrl.sv
// ----------------------------------------------------------------------------
// lris_ctrl
// Sequencer: steps through pre, tanh/leak, turnaround and readout phases.
// ----------------------------------------------------------------------------
`default_nettype none
module lris_ctrl import lris_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_clear,
    input  wire logic          i_out_free,
    output logic               o_busy,
    output t_state             o_state,
    output logic [NW-1:0]      o_n,
    output logic [NW:0]        o_k,
    output t_cmd               o_cmd
);
    // pre: k runs 0..IN_COLS+NEURONS (fetches 0..IN_COLS+NEURONS-1); readout: 0..OUT_COLS
    localparam int PRE_LEN = IN_COLS + NEURONS;
    localparam int KW      = $clog2(PRE_LEN + 2) + 1;

    t_state r_state, n_state;
    logic [NW-1:0] r_n, n_n;
    logic [KW-1:0] r_k, n_k;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    // The RAM read is registered: a MAC for fetch k happens at k+1.
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_k     = r_k;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_clear) begin
                    cmd.clr_x = 1'b1;
                end else if (i_start) begin
                    n_state = ST_PRE;
                    n_n     = '0;
                    n_k     = '0;
                end
            end
            ST_CLEAR: n_state = ST_IDLE;
            ST_PRE: begin
                cmd.src = (r_k < KW'(IN_COLS + 1)) ? SRC_IN : SRC_REC;
                if (r_k == KW'(1)) begin
                    cmd.clr_acc = 1'b1;
                end else if (r_k != '0) begin
                    cmd.mac = 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k == KW'(PRE_LEN)) begin
                    n_state = ST_PRE_END;
                end
            end
            ST_PRE_END: begin
                cmd.pre_done = 1'b1;
                n_k = '0;
                if (r_n == NW'(NEURONS - 1)) begin
                    n_state = ST_TANH;
                    n_n     = '0;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_state = ST_PRE;
                end
            end
            // Fetch pre and x of neuron n; they arrive in the next cycle.
            ST_TANH: begin
                n_state = ST_LEAK;
            end
            ST_LEAK: begin
                cmd.tanh_go = 1'b1;
                n_state = ST_LEAK_END;
            end
            ST_LEAK_END: begin
                cmd.leak_go = 1'b1;
                if (r_n == NW'(NEURONS - 1)) begin
                    n_state = ST_COPY;
                    n_n     = '0;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_state = ST_TANH;
                end
            end
            // Turnaround cycle before the readout rows.
            ST_COPY: begin
                n_state = ST_RO;
                n_k     = '0;
            end
            ST_RO: begin
                cmd.src = SRC_OUT;
                if (r_k == KW'(1)) begin
                    cmd.clr_acc = 1'b1;
                end else if (r_k != '0) begin
                    cmd.mac = 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k == KW'(OUT_COLS)) begin
                    n_state = ST_RO_END;
                end
            end
            ST_RO_END: begin
                if (i_out_free) begin
                    cmd.ro_done = 1'b1;
                    n_k = '0;
                    if (r_n == NW'(OUTPUT_DIM - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_state = ST_RO;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_state = r_state;
    assign o_n     = r_n;
    assign o_k     = (NW+1)'(r_k);
    assign o_cmd   = cmd;
endmodule
`default_nettype wire

// File: hw/rtl/lris_datapath.sv
// ----------------------------------------------------------------------------
// lris_datapath
// Weight memories, state and pre memories, one MAC, tanh and leak units.
// ----------------------------------------------------------------------------
`default_nettype none
module lris_datapath import lris_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  t_in_item           i_item,
    input  wire logic [12:0]   i_leak,
    input  t_state             i_state,
    input  wire logic [NW-1:0] i_n,
    input  wire logic [NW:0]   i_k,
    input  t_cmd               i_cmd,
    output logic               o_res_valid,
    output t_out_item          o_res
);
    localparam int KW = NW + 1;

    // Write side
    logic we_rec, we_in, we_out;
    logic [RW_AW-1:0]  wa_rec;
    logic [IW_AW-1:0]  wa_in;
    logic [OWT_AW-1:0] wa_out;
    assign we_rec = i_wr && i_item.action == ACT_WR_REC
                  && 32'(i_item.row) < NEURONS && 32'(i_item.col) < NEURONS;
    assign we_in  = i_wr && i_item.action == ACT_WR_IN
                  && 32'(i_item.row) < NEURONS && 32'(i_item.col) < IN_COLS;
    assign we_out = i_wr && i_item.action == ACT_WR_OUT
                  && 32'(i_item.row) < OUTPUT_DIM && 32'(i_item.col) < OUT_COLS;
    assign wa_rec = RW_AW'(32'(i_item.row) * NEURONS + 32'(i_item.col));
    assign wa_in  = IW_AW'(32'(i_item.row) * IN_COLS + 32'(i_item.col));
    assign wa_out = OWT_AW'(32'(i_item.row) * OUT_COLS + 32'(i_item.col));

    // Read addresses from sequencer index k
    logic [RW_AW-1:0]  ra_rec;
    logic [IW_AW-1:0]  ra_in;
    logic [OWT_AW-1:0] ra_out;
    assign ra_in  = IW_AW'(32'(i_n) * IN_COLS + 32'(i_k));
    assign ra_rec = RW_AW'(32'(i_n) * NEURONS + 32'(i_k) - IN_COLS);
    assign ra_out = OWT_AW'(32'(i_n) * OUT_COLS + 32'(i_k));

    logic [15:0] rd_rec, rd_in, rd_out;
    lris_ram #(.WIDTH(16), .DEPTH(RW_DEPTH)) u_rec (
        .i_clk(i_clk), .i_we(we_rec), .i_waddr(wa_rec), .i_wdata(i_item.value),
        .i_raddr(ra_rec), .o_rdata(rd_rec));
    lris_ram #(.WIDTH(16), .DEPTH(IW_DEPTH)) u_in (
        .i_clk(i_clk), .i_we(we_in), .i_waddr(wa_in), .i_wdata(i_item.value),
        .i_raddr(ra_in), .o_rdata(rd_in));
    lris_ram #(.WIDTH(16), .DEPTH(OWT_DEPTH)) u_out (
        .i_clk(i_clk), .i_we(we_out), .i_waddr(wa_out), .i_wdata(i_item.value),
        .i_raddr(ra_out), .o_rdata(rd_out));

    // Input vector, accumulator and tanh registers
    logic signed [15:0] r_u   [INPUT_DIM];
    logic [KW-1:0]      r_kd;      // fetch index of the data now on the RAM ports
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0] r_th;

    // Neuron state and pre live in RAMs. x updates in place: every pre is
    // done before the first leak write. A valid bit per neuron makes a
    // cleared state read as zero.
    logic [NW-1:0]      x_raddr;
    logic signed [15:0] rd_x, rd_pre, x_cur;
    logic [NEURONS-1:0] r_xv;
    logic               r_xv_rd;
    logic [12:0]        leak;
    logic signed [ACC_W-1:0] lacc;

    assign x_raddr = (i_state == ST_TANH || i_state == ST_LEAK) ? i_n
                                                                : NW'(32'(i_k) - IN_COLS);

    lris_ram #(.WIDTH(16), .DEPTH(NEURONS)) u_x (
        .i_clk(i_clk), .i_we(i_cmd.leak_go), .i_waddr(i_n), .i_wdata(rnd_sat(lacc)),
        .i_raddr(x_raddr), .o_rdata(rd_x));
    lris_ram #(.WIDTH(16), .DEPTH(NEURONS)) u_pre (
        .i_clk(i_clk), .i_we(i_cmd.pre_done), .i_waddr(i_n), .i_wdata(rnd_sat(r_acc)),
        .i_raddr(i_n), .o_rdata(rd_pre));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_x) begin
            r_xv <= '0;
        end else if (i_cmd.leak_go) begin
            r_xv[i_n] <= 1'b1;
        end
        r_xv_rd <= r_xv[x_raddr];
    end

    assign x_cur = r_xv_rd ? rd_x : 16'sd0;

    always_ff @(posedge i_clk) begin
        if (i_wr && i_item.action == ACT_ELEMENT
            && 32'(i_item.element_index) < INPUT_DIM) begin
            r_u[UW'(i_item.element_index)] <= i_item.value;
        end
        r_kd <= i_k;
    end

    // Operand select: column 0 is bias (times 1.0), then u, then x.
    logic signed [15:0] w_op, v_op;
    logic signed [31:0] prod;
    always_comb begin
        w_op = (i_cmd.src == SRC_IN) ? rd_in : (i_cmd.src == SRC_REC) ? rd_rec : rd_out;
        if (r_kd == '0) begin
            v_op = 16'sh1000;
        end else if (32'(r_kd) < IN_COLS) begin
            v_op = r_u[UW'(32'(r_kd) - 1)];
        end else begin
            v_op = x_cur;
        end
        prod = w_op * v_op;
    end

    // Operand RAM read is registered: mac at k uses fetch k-1.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_acc <= ACC_W'(prod);
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
    end

    // tanh: segment lookup and interpolation, registered
    logic [15:0] a_abs;
    logic [5:0]  seg;
    logic signed [13:0] t0, t1, tv;
    logic signed [25:0] ip;
    always_comb begin
        a_abs = rd_pre[15] ? 16'(-rd_pre) : rd_pre;
        seg   = a_abs[15:10];
        t0    = tanh_tab(seg);
        t1    = tanh_tab(seg + 6'd1);
        ip    = (t1 - t0) * $signed({1'b0, a_abs[9:0]}) + 26'sd512;
        tv    = (seg >= 6'd32) ? 14'sd4096 : 14'(t0 + 14'(ip >>> 10));
    end

    assign leak = (i_leak > 13'd4096) ? 13'd4096 : i_leak;
    assign lacc = ACC_W'($signed({1'b0, 13'd4096 - leak})) * ACC_W'(x_cur)
                + ACC_W'($signed({1'b0, leak})) * ACC_W'(r_th);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tanh_go) begin
            r_th <= rd_pre[15] ? 16'(-tv) : 16'(tv);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_cmd.ro_done) begin
            o_res_valid <= 1'b1;
        end else if (i_state == ST_IDLE || i_state == ST_RO) begin
            o_res_valid <= o_res_valid;
        end
        if (i_cmd.ro_done) begin
            o_res.output_index <= 3'(i_n);
            o_res.output_value <= rnd_sat(r_acc);
            o_res.last_output  <= (32'(i_n) == OUTPUT_DIM - 1);
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/leaky_reservoir_inference_step_unit.sv
// ----------------------------------------------------------------------------
// leaky_reservoir_inference_step_unit
// Echo state network inference step in Q4.12 with leaky state update.
// ----------------------------------------------------------------------------
// Write requests load weights. The input element at the last position
// starts a time step: one shared MAC walks NEURONS rows of
// (1+INPUT_DIM+NEURONS) products (one per cycle), then a tanh and leak
// pass runs per neuron (fetch, tanh, leak write), then a turnaround, then
// OUTPUT_DIM readout rows of (1+INPUT_DIM+NEURONS) products. The step is
// serialised by the single multiply-accumulate unit and the one read port
// of each memory; a result held by a stalled receiver delays every later
// row by the length of the stall. No request is taken while a step runs.
// A clear-state request clears the state while the sequencer stays idle.
`default_nettype none
module leaky_reservoir_inference_step_unit import lris_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  t_in_item         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_data
);
    logic [12:0] r_leak;
    logic        busy, acc_in, start, clr, res_valid, r_ov;
    t_state      state;
    logic [NW-1:0] n_idx;
    logic [NW:0]   k_idx;
    t_cmd          cmd;
    t_out_item     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak <= 13'd4096;
        end else if (i_cfg_we) begin
            r_leak <= i_cfg_wdata;
        end
    end

    // Accept requests only while the sequencer is idle.
    assign o_ready = !busy;
    assign acc_in  = i_valid && o_ready;
    assign start   = acc_in && i_data.action == ACT_ELEMENT
                   && 32'(i_data.element_index) == INPUT_DIM - 1;
    assign clr     = acc_in && i_data.action == ACT_CLEAR;

    lris_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_clear(clr),
        .i_out_free(!r_ov || i_ready), .o_busy(busy), .o_state(state),
        .o_n(n_idx), .o_k(k_idx), .o_cmd(cmd));

    lris_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(acc_in), .i_item(i_data),
        .i_leak(r_leak), .i_state(state), .i_n(n_idx), .i_k(k_idx),
        .i_cmd(cmd), .o_res_valid(res_valid), .o_res(res));

    // Output valid: set on each finished row, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (cmd.ro_done) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov && res_valid;
    assign o_data  = res;
endmodule
`default_nettype wire

// File: hw/rtl/lris_checker.sv
// ----------------------------------------------------------------------------
// lris_checker
// Port-level assertions for the reservoir step unit.
// ----------------------------------------------------------------------------
`default_nettype none
module lris_checker import lris_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_ready,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input t_out_item      o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    a_last_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_output |=> !o_valid)
        else $error("result shown after the last of a step");
    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_ready && !o_valid)
        else $error("not idle after reset");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last_output |->
        32'(o_data.output_index) == ((OUTPUT_DIM - 1) % 8))
        else $error("last flag on wrong index");
endmodule

bind leaky_reservoir_inference_step_unit lris_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));
`default_nettype wire
